// File: rtl/core/sorted_max_priority_queue_macros.svh
// assertion macros used by the queue datapath
`ifndef SORTED_MAX_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_MAX_PRIORITY_QUEUE_MACROS_SVH

// plain property checked on every rising clock edge outside reset
`define SMPQ_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define SMPQ_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SMPQ_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/smpq_pkg.sv
package smpq_pkg;

  localparam int DEPTH       = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(DEPTH + 1);

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [CNT_W-1:0]              count_t;

  // mode codes of an input word
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // capture the accepted word and the compare flags
    logic commit;  // update the cells and load the result register
  } smpq_cmd_t;

endpackage

// File: rtl/core/smpq_if.sv
// request channel
interface smpq_in_if;
  import smpq_pkg::*;

  logic   valid;
  logic   ready;
  logic   mode;
  value_t value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

// result channel
interface smpq_out_if;
  import smpq_pkg::*;

  logic   valid;
  logic   ready;
  value_t top_value;
  logic   top_valid;
  count_t entry_count;
  logic   overflow;

  modport source (output valid, output top_value, output top_valid,
                  output entry_count, output overflow, input ready);
  modport sink   (input valid, input top_value, input top_valid,
                  input entry_count, input overflow, output ready);
endinterface

// File: rtl/core/smpq_ctrl.sv
module smpq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output smpq_pkg::smpq_cmd_t cmd
);
  import smpq_pkg::*;

  typedef enum logic {IDLE, UPDATE} state_t;

  state_t state;
  logic   commit;

  // a word is taken only between operations
  assign in_ready = (state == IDLE);

  // commit once the result register is free or draining
  assign commit = (state == UPDATE) && (!out_valid || out_ready);

  assign cmd.load   = in_valid && in_ready;
  assign cmd.commit = commit;

  // state and result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            state <= UPDATE;
          end
        end
        UPDATE: begin
          if (commit) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/core/smpq_dp.sv
`include "sorted_max_priority_queue_macros.svh"

module smpq_dp (
  input  logic                clk,
  input  logic                rst,
  input  smpq_pkg::smpq_cmd_t cmd,
  input  logic                in_mode,
  input  smpq_pkg::value_t    in_value,
  output smpq_pkg::value_t    top_value,
  output logic                top_valid,
  output smpq_pkg::count_t    entry_count,
  output logic                overflow
);
  import smpq_pkg::*;

  value_t             entries [DEPTH];
  value_t             entries_next [DEPTH];
  count_t             count;
  count_t             count_next;
  logic [DEPTH-1:0]   ge_q;
  logic               mode_q;
  value_t             val_q;
  logic               dropped;

  // next cell contents: parallel insert or shift toward the top
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      entries_next[i] = entries[i];
    end
    count_next = count;
    dropped    = 1'b0;
    if (mode_q == MODE_INSERT) begin
      if (count == CNT_W'(DEPTH)) begin
        dropped = 1'b1;
      end else begin
        // cells at or above an equal-or-larger entry hold, the first
        // smaller cell takes the new word, the rest move down one
        entries_next[0] = ge_q[0] ? entries[0] : val_q;
        for (int i = 1; i < DEPTH; i++) begin
          if (ge_q[i]) begin
            entries_next[i] = entries[i];
          end else if (ge_q[i-1]) begin
            entries_next[i] = val_q;
          end else begin
            entries_next[i] = entries[i-1];
          end
        end
        count_next = count + 1'b1;
      end
    end else if (count != '0) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        entries_next[i] = entries[i+1];
      end
      count_next = count - 1'b1;
    end
  end

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.commit) begin
      count <= count_next;
    end
  end

  // captured word and per-cell compare flags
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q <= in_mode;
      val_q  <= in_value;
      for (int i = 0; i < DEPTH; i++) begin
        ge_q[i] <= (CNT_W'(i) < count) && (entries[i] >= in_value);
      end
    end
  end

  // cells and result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int i = 0; i < DEPTH; i++) begin
        entries[i] <= entries_next[i];
      end
      top_value   <= (count_next != '0) ? entries_next[0] : '0;
      top_valid   <= (count_next != '0);
      entry_count <= count_next;
      overflow    <= dropped;
    end
  end

  // checks
  `SMPQ_ASSERT(a_count_range, clk, rst, count <= CNT_W'(DEPTH), "occupancy above depth")
  `SMPQ_ASSERT_NXT(a_count_report, clk, rst, cmd.commit, entry_count == count,
                   "reported count differs from occupancy")
  `SMPQ_ASSERT_IMP(a_order, clk, rst, count >= CNT_W'(2), entries[0] >= entries[1],
                   "head cells out of order")
  `SMPQ_ASSERT_NXT(a_drop_full, clk, rst, cmd.commit && dropped,
                   entry_count == CNT_W'(DEPTH), "dropped insert while not full")
  `SMPQ_ASSERT_IMP(a_load_commit, clk, rst, cmd.load, !cmd.commit,
                   "capture and commit in one cycle")

endmodule

// File: rtl/core/sorted_max_priority_queue.sv
// channel  | dir | payload
// ---------+-----+--------------------------------------------------
// in_ch    | in  | mode, value
// out_ch   | out | top_value, top_valid, entry_count, overflow
//
// the accept edge registers the word and one compare flag per cell; the
// commit edge, once the result register is free, moves all cells at once
// a full result register that is not taken holds the update step
// rst (synchronous, active high) empties the queue; cell contents are kept
// out_ch.ready low only delays the commit; no word is lost or repeated
module sorted_max_priority_queue (
  input  logic       clk,
  input  logic       rst,
  smpq_in_if.sink    in_ch,
  smpq_out_if.source out_ch
);
  import smpq_pkg::*;

  smpq_cmd_t cmd;

  // sequencer
  smpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // sorted cells and result register
  smpq_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .in_mode     (in_ch.mode),
    .in_value    (in_ch.value),
    .top_value   (out_ch.top_value),
    .top_valid   (out_ch.top_valid),
    .entry_count (out_ch.entry_count),
    .overflow    (out_ch.overflow)
  );

endmodule

// File: dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import smpq_pkg::*;

  localparam int RANDOM_WORDS = 1330;
  localparam int RESET_CYCLES = 8;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 300000;
  // long receiver hold-off so the block backs up into the request channel
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 300;

  typedef struct packed {
    value_t top_value;
    logic   top_valid;
    count_t entry_count;
    logic   overflow;
  } queue_result_t;

  typedef struct packed {
    logic          mode;
    value_t        value;
    logic          typed;
    queue_result_t want;
  } stim_row_t;

  logic clk;
  logic rst;
  bit   reset_done;
  int   mismatch_count;
  bit   sender_no_idle;

  smpq_in_if  in_ch ();
  smpq_out_if out_ch ();

  sorted_max_priority_queue i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // mirror of the queue contents, largest first
  value_t        held_vals [DEPTH];
  int            held_cnt;
  queue_result_t expected_results [$];

  // directed words: empty remove, extremes, equal values, fill to full and overflow
  stim_row_t directed_rows [24] = '{
    '{MODE_REMOVE, 32'sh0000_0000, 1'b1, '{32'sh0000_0000, 1'b0, 5'd0, 1'b0}},
    '{MODE_INSERT, 32'sh7fff_ffff, 1'b1, '{32'sh7fff_ffff, 1'b1, 5'd1, 1'b0}},
    '{MODE_INSERT, 32'sh8000_0000, 1'b1, '{32'sh7fff_ffff, 1'b1, 5'd2, 1'b0}},
    '{MODE_INSERT, 32'sh0000_0000, 1'b0, '0},
    '{MODE_INSERT, 32'shffff_ffff, 1'b0, '0},
    '{MODE_INSERT, 32'sh0000_0000, 1'b0, '0},
    '{MODE_REMOVE, 32'shffff_ffff, 1'b0, '0},
    '{MODE_INSERT, 32'sh8000_0000, 1'b0, '0},
    '{MODE_INSERT, 32'sh0000_0001, 1'b0, '0},
    '{MODE_INSERT, 32'sh7fff_ffff, 1'b0, '0},
    '{MODE_INSERT, 32'sh7fff_ffff, 1'b0, '0},
    '{MODE_INSERT, 32'sh5555_5555, 1'b0, '0},
    '{MODE_INSERT, 32'shaaaa_aaaa, 1'b0, '0},
    '{MODE_INSERT, 32'sh0000_0002, 1'b0, '0},
    '{MODE_INSERT, 32'shffff_fffe, 1'b0, '0},
    '{MODE_INSERT, 32'sh1234_5678, 1'b0, '0},
    '{MODE_INSERT, 32'sh0000_0001, 1'b0, '0},
    '{MODE_INSERT, 32'sh0000_0000, 1'b0, '0},
    '{MODE_INSERT, 32'sh7fff_fffe, 1'b0, '0},
    '{MODE_INSERT, 32'sh0000_0003, 1'b1, '{32'sh7fff_ffff, 1'b1, 5'd16, 1'b1}},
    '{MODE_REMOVE, 32'sh0000_0000, 1'b0, '0},
    '{MODE_INSERT, 32'sh8000_0000, 1'b0, '0},
    '{MODE_INSERT, 32'sh8000_0000, 1'b1, '{32'sh7fff_ffff, 1'b1, 5'd16, 1'b1}},
    '{MODE_REMOVE, 32'sh0000_0000, 1'b0, '0}
  };

  // apply one word to the mirror and return the status it produces
  function automatic queue_result_t apply_word(input logic mode, input value_t value);
    queue_result_t res;
    int pos;
    int i;
    res = '0;
    if (mode == MODE_INSERT) begin
      if (held_cnt >= DEPTH) begin
        res.overflow = 1'b1;
      end else begin
        // new value goes behind every entry equal to or larger than it
        pos = 0;
        while (pos < held_cnt && held_vals[pos] >= value) pos++;
        for (i = held_cnt; i > pos; i--) held_vals[i] = held_vals[i-1];
        held_vals[pos] = value;
        held_cnt++;
      end
    end else if (held_cnt > 0) begin
      for (i = 0; i + 1 < held_cnt; i++) held_vals[i] = held_vals[i+1];
      held_cnt--;
    end
    res.top_value   = (held_cnt > 0) ? held_vals[0] : '0;
    res.top_valid   = (held_cnt > 0);
    res.entry_count = count_t'(held_cnt);
    return res;
  endfunction

  // insert values: wide random, small signed range, extremes, or a copy of a held entry
  function automatic value_t random_value();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return value_t'($urandom);
    if (pick < 70) return value_t'($signed($urandom_range(0, 15)) - 8);
    if (pick < 85) begin
      case ($urandom_range(0, 3))
        0: return 32'sh7fff_ffff;
        1: return 32'sh8000_0000;
        2: return 32'sh0000_0000;
        default: return 32'shffff_ffff;
      endcase
    end
    if (held_cnt > 0) return held_vals[$urandom_range(0, held_cnt - 1)];
    return value_t'($urandom);
  endfunction

  // offer one word, wait for acceptance, then record its expected status
  task automatic send_word(input logic mode, input value_t value, input logic typed,
                           input queue_result_t typed_res);
    int gap;
    queue_result_t predicted;
    if ($urandom_range(0, 39) == 0) sender_no_idle = !sender_no_idle;
    gap = sender_no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode  <= mode;
    in_ch.value <= value;
    do @(posedge clk); while (!in_ch.ready);
    predicted = apply_word(mode, value);
    expected_results.push_back(typed ? typed_res : predicted);
  endtask

  // compare one status word with the oldest expectation
  task automatic check_result(input queue_result_t got);
    queue_result_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected word: top_value %0d top_valid %0b entry_count %0d overflow %0b",
               $time, got.top_value, got.top_valid, got.entry_count, got.overflow);
      mismatch_count++;
    end else begin
      want = expected_results.pop_front();
      if (got.top_value !== want.top_value) begin
        $display("%0t: top_value expected %0d got %0d", $time, want.top_value, got.top_value);
        mismatch_count++;
      end
      if (got.top_valid !== want.top_valid) begin
        $display("%0t: top_valid expected %0b got %0b", $time, want.top_valid, got.top_valid);
        mismatch_count++;
      end
      if (got.entry_count !== want.entry_count) begin
        $display("%0t: entry_count expected %0d got %0d", $time, want.entry_count,
                 got.entry_count);
        mismatch_count++;
      end
      if (got.overflow !== want.overflow) begin
        $display("%0t: overflow expected %0b got %0b", $time, want.overflow, got.overflow);
        mismatch_count++;
      end
    end
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side: random stalls, idle-free stretches and one long hold-off
  initial begin : result_sink
    int wait_cycles;
    int taken;
    bit no_stall;
    queue_result_t got;
    taken    = 0;
    no_stall = 1'b0;
    out_ch.ready <= 1'b0;
    wait (reset_done);
    forever begin
      if ($urandom_range(0, 39) == 0) no_stall = !no_stall;
      wait_cycles = no_stall ? 0 : $urandom_range(0, 5);
      if (taken == HOLD_AT) wait_cycles = HOLD_CYCLES;
      if (wait_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.top_value   = out_ch.top_value;
      got.top_valid   = out_ch.top_valid;
      got.entry_count = out_ch.entry_count;
      got.overflow    = out_ch.overflow;
      check_result(got);
      taken++;
    end
  end

  // request side and end of run
  initial begin : stimulus
    int n;
    int phase_left;
    int insert_pct;
    rst            <= 1'b1;
    in_ch.valid    <= 1'b0;
    in_ch.mode     <= MODE_INSERT;
    in_ch.value    <= '0;
    held_cnt       = 0;
    mismatch_count = 0;
    sender_no_idle = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst        <= 1'b0;
    reset_done = 1'b1;

    // directed table
    for (n = 0; n < $size(directed_rows); n++) begin
      send_word(directed_rows[n].mode, directed_rows[n].value, directed_rows[n].typed,
                directed_rows[n].want);
    end

    // random phases that lean toward filling, churning or draining
    phase_left = 0;
    insert_pct = 50;
    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 80);
        case ($urandom_range(0, 2))
          0: insert_pct = 85;
          1: insert_pct = 50;
          default: insert_pct = 15;
        endcase
      end
      phase_left--;
      if ($urandom_range(0, 99) < insert_pct) begin
        send_word(MODE_INSERT, random_value(), 1'b0, '0);
      end else begin
        send_word(MODE_REMOVE, value_t'($urandom), 1'b0, '0);
      end
    end
    in_ch.valid <= 1'b0;

    // drain
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
